// File: rtl/mlpq_pkg.sv
// Package for the multilevel priority queue: transaction payload types,
// operation and status codes, controller state and control structs.
// No dependencies.
`default_nettype none

package mlpq_pkg;

  typedef struct packed {
    logic               func;
    logic [3:0]         priority_req;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [3:0]         out_priority;
  } rsp_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BADPRIO   = 2'd1;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// File: rtl/mlpq_ctrl.sv
// Controller for the multilevel priority queue: sequences capture, execute
// and result load for one transaction at a time. Uses mlpq_pkg.
`default_nettype none

module mlpq_ctrl
  import mlpq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  output logic         req_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall   = 1'b0;
        cmd.capture = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_LOAD: begin
        cmd.load = sts.out_free;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mlpq_datapath.sv
// Datapath for the multilevel priority queue: per-level ring pointers and
// empty flags, the item memory, and the result register. Uses mlpq_pkg.
`default_nettype none

module mlpq_datapath
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 8
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire req_t    req,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts,
  output logic         rsp_valid,
  input  wire logic    rsp_stall,
  output rsp_t         rsp
);

  localparam int LVL_W  = $clog2(NUM_LEVELS);
  localparam int SLOT_W = $clog2(LEVEL_DEPTH);
  localparam int ADDR_W = LVL_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : SLOT_W'(s + 1'b1);
  endfunction

  req_t              cur;
  logic [SLOT_W-1:0] head [NUM_LEVELS];
  logic [SLOT_W-1:0] tail [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] empty;
  logic [31:0]       mem [MEM_DEPTH];
  logic [31:0]       rd_data;
  logic [1:0]        res_status;
  logic [LVL_W-1:0]  res_level;
  logic              res_take;

  logic              is_remove;
  logic              bad_level;
  logic              found;
  logic [LVL_W-1:0]  first_lvl;
  logic [LVL_W-1:0]  sel;
  logic [SLOT_W-1:0] sel_head;
  logic [SLOT_W-1:0] sel_tail;
  logic              sel_empty;
  logic [SLOT_W-1:0] tail_nx;
  logic              full;
  logic              ins_ok;
  logic              rm_ok;
  logic [1:0]        status_now;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    found     = 1'b0;
    first_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (!empty[i]) begin
        found     = 1'b1;
        first_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    is_remove = (cur.func == FUNC_REMOVE);
    bad_level = ({1'b0, cur.priority_req} >= 5'(NUM_LEVELS));
    sel       = is_remove ? first_lvl : cur.priority_req[LVL_W-1:0];
    sel_head  = head[sel];
    sel_tail  = tail[sel];
    sel_empty = empty[sel];
    tail_nx   = ring_next(sel_tail);
    full      = !sel_empty && (tail_nx == sel_head);
    ins_ok    = !is_remove && !bad_level && !full;
    rm_ok     = is_remove && found;
    priority if (is_remove && !found) begin
      status_now = STAT_UNDERFLOW;
    end else if (!is_remove && bad_level) begin
      status_now = STAT_BADPRIO;
    end else if (!is_remove && full) begin
      status_now = STAT_OVERFLOW;
    end else begin
      status_now = STAT_OK;
    end
    mem_we    = cmd.exec && ins_ok;
    mem_waddr = {sel, (sel_empty ? SLOT_W'(0) : tail_nx)};
    mem_re    = cmd.exec && rm_ok;
    mem_raddr = {sel, sel_head};
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= cur.value;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
      end
      empty <= '1;
    end else if (cmd.exec) begin
      if (ins_ok) begin
        if (sel_empty) begin
          head[sel]  <= '0;
          tail[sel]  <= '0;
          empty[sel] <= 1'b0;
        end else begin
          tail[sel] <= tail_nx;
        end
      end else if (rm_ok) begin
        if (sel_head == sel_tail) begin
          empty[sel] <= 1'b1;
        end else begin
          head[sel] <= ring_next(sel_head);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur <= req;
    end
    if (cmd.exec) begin
      res_status <= status_now;
      res_level  <= sel;
      res_take   <= rm_ok;
    end
    if (cmd.load) begin
      rsp.status       <= res_status;
      rsp.out_value    <= res_take ? rd_data : '0;
      rsp.out_priority <= res_take ? 4'(res_level) : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign sts.out_free = !rsp_valid || !rsp_stall;

endmodule

`default_nettype wire

// File: rtl/multilevel_priority_queue.sv
// Multilevel priority queue: one ring FIFO per priority level, level 0 first.
// Request channel req (insert or remove), response channel rsp, one response
// per request. req_valid/req_stall and rsp_valid/rsp_stall: a transaction
// completes on a clock edge with valid high and stall low.
// An insert names a level and a value; it is refused with status 1 when the
// level is out of range and status 2 when that level is full. A remove
// returns the oldest value of the lowest-numbered non-empty level with its
// level, or status 3 when all levels are empty. Refusals change nothing.
// One request is in flight at a time: a new request is taken only after the
// last one has passed through its steps, in order: capture, execute with
// at most one item memory access, load into the response register.
// The response register is separate: req_stall drops again once a response
// is loaded, even while it waits. When rsp_stall holds and a newer response
// is ready, the block waits in its load step with req_stall high.
// Reset (synchronous, rst high) marks every level empty and clears the
// pointers; memory contents are not cleared.
// Uses mlpq_pkg, mlpq_ctrl and mlpq_datapath.
`default_nettype none

module multilevel_priority_queue
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS  = 4,
  parameter int LEVEL_DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mlpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlpq_datapath #(
    .NUM_LEVELS  (NUM_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// File: rtl/mlpq_checker.sv
// Port-level checker for the multilevel priority queue, bound to the top
// level. Uses mlpq_pkg.
`default_nettype none

module mlpq_checker
  import mlpq_pkg::*;
#(
  parameter int NUM_LEVELS = 4
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic req_valid,
  input wire logic req_stall,
  input wire req_t req,
  input wire logic rsp_valid,
  input wire logic rsp_stall,
  input wire rsp_t rsp
);

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while previous transaction in flight");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != STAT_OK) |-> (rsp.out_value == 0) && (rsp.out_priority == 0))
    else $error("refused transaction returned data");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ({1'b0, rsp.out_priority} < 5'(NUM_LEVELS)))
    else $error("response level out of range");

endmodule

bind multilevel_priority_queue mlpq_checker #(
  .NUM_LEVELS (NUM_LEVELS)
) u_mlpq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
